@@ rtl/dotted_ipv4_address_parser_assert.svh @@
// Assertion macros for the parser top, which checks its own logic.
`ifndef DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DIPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DIPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/dipa_pkg.sv @@
package dipa_pkg;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAIL   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        t_phase            phase;
        t_radix            radix;
        logic [31:0]       acc;
        logic              ovf;
        logic [2:0][7:0]   parts;
        logic [1:0]        count;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_START,
        radix: RX_DEC,
        acc:   32'd0,
        ovf:   1'b0,
        parts: '0,
        count: 2'd0
    };

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0]  PARTS_FULL   = 2'd3;
    localparam logic [31:0] PART8_MAX    = 32'h0000_00FF;
    localparam logic [31:0] PART16_MAX   = 32'h0000_FFFF;
    localparam logic [31:0] PART24_MAX   = 32'h00FF_FFFF;
    localparam logic [31:0] ADDR_INVALID = 32'hFFFF_FFFF;

endpackage

@@ rtl/dipa_step.sv @@
module dipa_step import dipa_pkg::*; (
    input  t_state      i_state,
    input  logic [7:0]  i_char,
    output t_state      o_state,
    output logic [31:0] o_address,
    output logic        o_ok
);

    t_radix      eff_radix;
    logic        is_dec;
    logic        is_hex_letter;
    logic        is_space;
    logic [3:0]  digit;
    logic [35:0] prod;
    logic [35:0] sum;
    logic        dig_en;
    logic        fit;
    logic        phase_ok;
    logic [31:0] addr;

    // A fresh part always starts in decimal.
    assign eff_radix = (i_state.phase == PH_START) ? RX_DEC : i_state.radix;

    always_comb begin
        is_dec        = i_char inside {[CH_0:CH_9]};
        is_hex_letter = (eff_radix == RX_HEX)
                        && (i_char inside {[CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]});
        is_space      = i_char inside {CH_SPACE, [CH_TAB:CH_CR]};
        digit         = is_dec ? i_char[3:0] : 4'(i_char[3:0] + 4'd9);
    end

    always_comb begin
        case (eff_radix)
            RX_HEX:  prod = {i_state.acc, 4'b0000};
            RX_OCT:  prod = {1'b0, i_state.acc, 3'b000};
            default: prod = {1'b0, i_state.acc, 3'b000} + {3'b000, i_state.acc, 1'b0};
        endcase
        sum = prod + {32'd0, digit};
    end

    always_comb begin
        dig_en = 1'b0;
        case (i_state.phase)
            PH_START:  dig_en = (i_char != CH_0);
            PH_ZERO:   dig_en = (i_char != CH_LC_X) && (i_char != CH_UC_X);
            PH_DIGITS: dig_en = 1'b1;
            default:   dig_en = 1'b0;
        endcase
    end

    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            PH_START: begin
                if (i_char == CH_0) begin
                    o_state.acc   = 32'd0;
                    o_state.radix = RX_OCT;
                    o_state.phase = PH_ZERO;
                end else begin
                    o_state.radix = RX_DEC;
                    o_state.phase = PH_DIGITS;
                end
            end
            PH_ZERO: begin
                o_state.phase = PH_DIGITS;
                if (!dig_en) begin
                    o_state.radix = RX_HEX;
                end
            end
            default: begin
            end
        endcase

        if (dig_en) begin
            if (is_dec || is_hex_letter) begin
                o_state.acc = sum[31:0];
                if (sum[35:32] != 4'd0) begin
                    o_state.ovf = 1'b1;
                end
            end else if (i_char == CH_DOT) begin
                if (i_state.count == PARTS_FULL || i_state.ovf || i_state.acc > PART8_MAX) begin
                    o_state.phase = PH_FAIL;
                end else begin
                    case (i_state.count)
                        2'd0:    o_state.parts[0] = i_state.acc[7:0];
                        2'd1:    o_state.parts[1] = i_state.acc[7:0];
                        default: o_state.parts[2] = i_state.acc[7:0];
                    endcase
                    o_state.count = 2'(i_state.count + 2'd1);
                    o_state.acc   = 32'd0;
                    o_state.radix = RX_DEC;
                    o_state.phase = PH_START;
                end
            end else if (is_space) begin
                o_state.phase = PH_DONE;
            end else begin
                o_state.phase = PH_FAIL;
            end
        end
    end

    // Join the stored parts with the last one at the terminator.
    always_comb begin
        phase_ok = (i_state.phase == PH_START) || (i_state.phase == PH_ZERO)
                   || (i_state.phase == PH_DIGITS) || (i_state.phase == PH_DONE);
        case (i_state.count)
            2'd0: begin
                fit  = 1'b1;
                addr = i_state.acc;
            end
            2'd1: begin
                fit  = (i_state.acc <= PART24_MAX);
                addr = {i_state.parts[0], i_state.acc[23:0]};
            end
            2'd2: begin
                fit  = (i_state.acc <= PART16_MAX);
                addr = {i_state.parts[0], i_state.parts[1], i_state.acc[15:0]};
            end
            default: begin
                fit  = (i_state.acc <= PART8_MAX);
                addr = {i_state.parts[0], i_state.parts[1], i_state.parts[2],
                        i_state.acc[7:0]};
            end
        endcase
        o_ok      = phase_ok && !i_state.ovf && fit;
        o_address = o_ok ? addr : ADDR_INVALID;
    end

endmodule

@@ rtl/dotted_ipv4_address_parser.sv @@
// Parses a dotted IPv4 address (decimal, octal with a leading 0, hex with a leading 0x, one to
// four parts) sent one character per transaction, and gives one result transaction when the NUL
// terminator arrives: the 32-bit address and o_valid_res, or all ones with o_valid_res low when
// the parse fails. A character is taken in every cycle while the input is not stalled; each one
// passes an input register and updates the parse state in the following cycle, and the result
// is written to the result register when the NUL leaves the input register. The input stalls
// only while a NUL waits in the input register behind a result that has not yet been taken.
// After each NUL the parser is back in its reset state.
module dotted_ipv4_address_parser import dipa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_address,
    output logic        o_valid_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    logic [31:0] r_address;
    logic        r_ok;
    logic [31:0] n_address;
    logic        n_ok;
    logic        is_nul;
    logic        proceed;

    dipa_step u_step (
        .i_state   (r_state),
        .i_char    (r_in_char),
        .o_state   (n_state),
        .o_address (n_address),
        .o_ok      (n_ok)
    );

    assign is_nul     = (r_in_char == CH_NUL);
    assign proceed    = r_in_valid && (!is_nul || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready) begin
            r_in_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (proceed) begin
            // Drop all state at the terminator.
            r_state <= is_nul ? STATE_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && is_nul) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proceed && is_nul) begin
            r_address <= n_address;
            r_ok      <= n_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_address   = r_address;
    assign o_valid_res = r_ok;

`include "dotted_ipv4_address_parser_assert.svh"

    `DIPA_ASSERT(a_fail_all_ones, (o_out_valid && !o_valid_res) |-> (o_address == ADDR_INVALID), "failed parse must give all ones")
    `DIPA_ASSERT(a_nul_clears, (proceed && is_nul) |=> (r_state.phase == PH_START && r_state.count == 2'd0 && !r_state.ovf), "state not cleared after terminator")
    `DIPA_ASSERT(a_char_no_stall, (r_in_valid && !is_nul) |-> proceed, "ordinary character stalled")
    `DIPA_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!r_out_valid && !r_in_valid), "reset left a transaction pending")

endmodule

@@ tb/dotted_ipv4_address_parser_tb.sv @@
module dotted_ipv4_address_parser_tb;
    import dipa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } t_parse_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_code = CH_NUL;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_address;
    logic        o_valid_res;

    // Parser state as predicted from the accepted characters
    t_phase      cur_phase;
    t_radix      cur_radix;
    logic [31:0] part_acc;
    logic        part_ovf;
    logic [7:0]  done_parts [3];
    logic [1:0]  done_count;

    t_parse_result addr_results [$];
    t_parse_result want;
    logic [7:0]    line_buf [$];
    int unsigned   sent_count    = 0;
    int unsigned   fail_count    = 0;
    int unsigned   hold_request  = 0;
    logic          hold_active   = 1'b0;
    logic          quiet         = 1'b0;

    dotted_ipv4_address_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_address   (o_address),
        .o_valid_res (o_valid_res)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_parse();
        cur_phase  = PH_START;
        cur_radix  = RX_DEC;
        part_acc   = '0;
        part_ovf   = 1'b0;
        done_parts = '{default: '0};
        done_count = '0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void take_digit(input int unsigned d);
        logic [63:0] base;
        logic [63:0] v;
        base = (cur_radix == RX_HEX) ? 64'd16 : (cur_radix == RX_OCT) ? 64'd8 : 64'd10;
        v = {32'd0, part_acc} * base + d;
        if (v[63:32] != '0) part_ovf = 1'b1;
        part_acc = v[31:0];
    endfunction

    function automatic void scan_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            take_digit(c - CH_0);
        end else if (cur_radix == RX_HEX && c >= CH_LC_A && c <= CH_LC_F) begin
            take_digit(c - CH_LC_A + 10);
        end else if (cur_radix == RX_HEX && c >= CH_UC_A && c <= CH_UC_F) begin
            take_digit(c - CH_UC_A + 10);
        end else if (c == CH_DOT) begin
            if (done_count >= PARTS_FULL || part_ovf || part_acc > PART8_MAX) begin
                cur_phase = PH_FAIL;
            end else begin
                done_parts[done_count] = part_acc[7:0];
                done_count = done_count + 2'd1;
                part_acc   = '0;
                cur_radix  = RX_DEC;
                cur_phase  = PH_START;
            end
        end else if (is_blank(c)) begin
            cur_phase = PH_DONE;
        end else begin
            cur_phase = PH_FAIL;
        end
    endfunction

    function automatic logic close_address(output logic [31:0] addr);
        addr = ADDR_INVALID;
        if (cur_phase == PH_FAIL || part_ovf) return 1'b0;
        if (done_count == 2'd0) begin
            addr = part_acc;
        end else if (done_count == 2'd1) begin
            if (part_acc > PART24_MAX) return 1'b0;
            addr = {done_parts[0], part_acc[23:0]};
        end else if (done_count == 2'd2) begin
            if (part_acc > PART16_MAX) return 1'b0;
            addr = {done_parts[0], done_parts[1], part_acc[15:0]};
        end else begin
            if (part_acc > PART8_MAX) return 1'b0;
            addr = {done_parts[0], done_parts[1], done_parts[2], part_acc[7:0]};
        end
        return 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        t_parse_result r;
        if (c == CH_NUL) begin
            r.ok = close_address(r.address);
            if (!r.ok) r.address = ADDR_INVALID;
            addr_results.push_back(r);
            clear_parse();
        end else begin
            case (cur_phase)
                PH_START: begin
                    if (c == CH_0) begin
                        part_acc  = '0;
                        cur_radix = RX_OCT;
                        cur_phase = PH_ZERO;
                    end else begin
                        cur_radix = RX_DEC;
                        cur_phase = PH_DIGITS;
                        scan_digit(c);
                    end
                end
                PH_ZERO: begin
                    cur_phase = PH_DIGITS;
                    if (c == CH_LC_X || c == CH_UC_X) cur_radix = RX_HEX;
                    else scan_digit(c);
                end
                PH_DIGITS: scan_digit(c);
                default: ;
            endcase
        end
    endfunction

    // Predict on every character transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
        end else if (i_in_valid && o_in_ready) begin
            parse_char(i_char_code);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (addr_results.size() == 0) begin
                $display("%0t: unexpected result address=%h valid_res=%b",
                         $time, o_address, o_valid_res);
                fail_count++;
            end else begin
                want = addr_results.pop_front();
                if (o_address !== want.address) begin
                    $display("%0t: address expected %h actual %h", $time, want.address, o_address);
                    fail_count++;
                end
                if (o_valid_res !== want.ok) begin
                    $display("%0t: valid_res expected %b actual %b", $time, want.ok, o_valid_res);
                    fail_count++;
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus one long hold when a test asks for it
    initial begin : result_sink
        int unsigned n;
        @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                n = hold_request;
                hold_request = 0;
                hold_active = 1'b1;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                n = pick_stall();
                if (n != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Call at a rising edge; returns at the edge that accepts the transaction
    task automatic send_char(input logic [7:0] c);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic void add_byte(input logic [7:0] c);
        line_buf.push_back(c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i]);
        send_char(CH_NUL);
        line_buf.delete();
    endtask

    // Call at a rising edge; drop valid and hold until every expected result is in
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (addr_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] max);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return max;
            2: return max + 32'd1;
            default: return $urandom & max;
        endcase
    endfunction

    function automatic string part_text(input logic [31:0] value);
        string digits;
        string prefix;
        case ($urandom_range(0, 9))
            0: return "";
            1, 2: return $sformatf("0%0o", value);
            // decimal digits behind a leading zero: octal with 8 and 9 let through
            3: return $sformatf("0%0d", value);
            4, 5: begin
                digits = $sformatf("%0h", value);
                if ($urandom_range(0, 1) != 0) digits = digits.toupper();
                prefix = ($urandom_range(0, 1) != 0) ? "0x" : "0X";
                return {prefix, digits};
            end
            default: return $sformatf("%0d", value);
        endcase
    endfunction

    function automatic void add_address();
        int unsigned n;
        logic [31:0] last_max;
        logic [7:0]  blank;
        n = $urandom_range(1, 4);
        for (int i = 1; i < n; i++) begin
            add_text(part_text(pick_value(PART8_MAX)));
            add_byte(CH_DOT);
        end
        last_max = (n == 1) ? ADDR_INVALID : (n == 2) ? PART24_MAX :
                   (n == 3) ? PART16_MAX : PART8_MAX;
        add_text(part_text(pick_value(last_max)));
        // push a lone part past 32 bits now and then
        if (n == 1 && $urandom_range(0, 7) == 0) add_text("5");
        case ($urandom_range(0, 7))
            0: begin
                blank = ($urandom_range(0, 2) == 0) ? CH_SPACE
                                                    : 8'($urandom_range(CH_TAB, CH_CR));
                add_byte(blank);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(1, 255)));
            end
            1: add_byte(8'($urandom_range(1, 255)));
            default: ;
        endcase
    endfunction

    task automatic test_directed_strings();
        send_line();
        add_text("0x");              send_line();
        add_text("1..2");            send_line();
        add_text("09 z");            send_line();
        add_text("0XaF");            send_line();
        add_text("....");            send_line();
        add_text("256.");            send_line();
        add_text("...256");          send_line();
        add_text("4294967296");      send_line();
        add_text("255.255.255.255"); send_line();
        add_byte(8'hFF);             send_line();
    endtask

    // Stall results long enough that a waiting result blocks the next NUL
    task automatic test_result_hold();
        i_in_valid <= 1'b0;
        hold_request = HOLD_CYCLES;
        while (!hold_active) @(posedge i_clk);
        for (int i = 0; i < 12; i++) begin
            add_text($sformatf("%0d", i));
            send_line();
        end
        wait_for_results();
    endtask

    task automatic test_random_addresses(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = sent_count + budget;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 13) begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_address();
                // corrupt one character of the address
                if (pick < 25 && line_buf.size() != 0)
                    line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(1, 255));
            end
            send_line();
        end
    endtask

    task automatic test_unthrottled_stream(input int unsigned budget);
        quiet = 1'b1;
        test_random_addresses(budget);
        quiet = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_strings();
        test_result_hold();
        test_random_addresses(450);
        wait_for_results();
        test_unthrottled_stream(150);
        test_random_addresses(350);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (addr_results.size() != 0) begin
            $display("%0t: results expected %0d actual 0", $time, addr_results.size());
            fail_count++;
        end
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
